[rtl/assert_macros.svh]
// assertion macros shared by iesp_decoder and iesp_out_reg
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/iesp_pkg.sv]
// shared widths, codes and types of the index entry stream parser
package iesp_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 5;
  localparam int WORD_W  = 32;
  localparam int MTYPE_W = 4;
  localparam int PERMS_W = 9;
  localparam int STAGE_W = 2;
  localparam int NLEN_W  = 12;
  localparam int ECODE_W = 3;

  // result kinds
  localparam logic [KIND_W-1:0] K_VERSION = 5'd0;
  localparam logic [KIND_W-1:0] K_COUNT   = 5'd1;
  localparam logic [KIND_W-1:0] K_FLAGS   = 5'd17;
  localparam logic [KIND_W-1:0] K_NAME    = 5'd18;
  localparam logic [KIND_W-1:0] K_END     = 5'd19;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd20;

  // error codes
  localparam logic [ECODE_W-1:0] E_NONE       = 3'd0;
  localparam logic [ECODE_W-1:0] E_SIGNATURE  = 3'd1;
  localparam logic [ECODE_W-1:0] E_UNUSED     = 3'd2;
  localparam logic [ECODE_W-1:0] E_MODE_TYPE  = 3'd3;
  localparam logic [ECODE_W-1:0] E_EXTENDED   = 3'd4;
  localparam logic [ECODE_W-1:0] E_LONG_NAME  = 3'd5;

  localparam logic [WORD_W-1:0]  SIG_WORD    = 32'h4449_5243;  // "DIRC"
  localparam logic [MTYPE_W-1:0] MT_REGULAR  = 4'b1000;
  localparam logic [MTYPE_W-1:0] MT_SYMLINK  = 4'b1010;
  localparam logic [MTYPE_W-1:0] MT_GITLINK  = 4'b1110;
  localparam logic [15:0]        FL_ASSUME   = 16'b1000_0000_0000_0000;
  localparam logic [15:0]        FL_EXTENDED = 16'b0100_0000_0000_0000;
  localparam logic [NLEN_W-1:0]  NAME_MAX    = 12'hFFF;
  localparam logic [2:0]         FIXED_MOD8  = 3'd6;  // 62-byte fixed part mod 8

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  entry_number;
    logic [MTYPE_W-1:0] file_type;
    logic [PERMS_W-1:0] perm_bits;
    logic               assume_valid;
    logic [STAGE_W-1:0] stage;
    logic [NLEN_W-1:0]  name_len;
    logic [ECODE_W-1:0] error_code;
    logic               last;
  } res_t;

endpackage

[rtl/iesp_ifs.sv]
// valid/ready channel interfaces for input bytes and parse results

interface iesp_in_if;
  import iesp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;
  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

interface iesp_out_if;
  import iesp_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [WORD_W-1:0]  value;
  logic [WORD_W-1:0]  entry_number;
  logic [MTYPE_W-1:0] file_type;
  logic [PERMS_W-1:0] perm_bits;
  logic               assume_valid;
  logic [STAGE_W-1:0] stage;
  logic [NLEN_W-1:0]  name_len;
  logic [ECODE_W-1:0] error_code;
  logic               last;
  modport source (output valid, kind, value, entry_number, file_type, perm_bits,
                  assume_valid, stage, name_len, error_code, last, input ready);
  modport sink (input valid, kind, value, entry_number, file_type, perm_bits,
                assume_valid, stage, name_len, error_code, last, output ready);
endinterface

[rtl/index_entry_stream_parser_top.sv]
// top level of the index entry stream parser
// usage:
//   in_chan  - valid/ready byte stream of an index file; frame_start marks the
//              first byte of a file and restarts the parse with that byte
//   out_chan - valid/ready stream of results: version, count, each entry word,
//              flags, name bytes, an entry end, or a sticky error
//   a transfer happens on a rising clk edge with valid and ready both high
// path: a byte that completes a field is held in the input register, decoded
//   and loaded into the result register, which drives its result on out_chan
// throughput: one byte per cycle while out_chan does not stall, set by the single
//   decode step between the input register and the result register; bytes that
//   finish no field (partial words, padding, ignored tail) give no result
// reset: rst_n low on a clock edge empties both registers and parks the parser;
//   bytes are ignored until a frame start
// stall: while out_chan.ready is low a waiting result holds and the input
//   register keeps one more byte, after which in_chan.ready drops
module index_entry_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  iesp_in_if.sink     in_chan,
  iesp_out_if.source  out_chan
);
  import iesp_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     advance;
  logic     step;
  logic     res_valid;
  res_t     res;

  // the held byte moves on whenever the result register can take its outcome
  assign step = item_valid && advance;

  iesp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  iesp_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  iesp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_chan  (out_chan)
  );
endmodule

[rtl/iesp_in_reg.sv]
// input register stage holding one accepted byte
module iesp_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  iesp_in_if.sink            in_chan,
  input  logic               advance,
  output logic               item_valid,
  output iesp_pkg::in_item_t item
);
  import iesp_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_chan.ready = !valid_r || advance;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte   <= in_chan.data_byte;
      item_r.frame_start <= in_chan.frame_start;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

[rtl/iesp_decoder.sv]
// parse state machine: one byte in, at most one result out per step
`include "assert_macros.svh"
module iesp_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  iesp_pkg::in_item_t item,
  output logic               res_valid,
  output iesp_pkg::res_t     res
);
  import iesp_pkg::*;

  localparam int PHASE_W = 5;
  localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
  localparam logic [PHASE_W-1:0] PH_SIG   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_VER   = 5'd2;
  localparam logic [PHASE_W-1:0] PH_CNT   = 5'd3;
  localparam logic [PHASE_W-1:0] PH_FIRST = 5'd4;
  localparam logic [PHASE_W-1:0] PH_MODE  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_FLAGS = 5'd19;
  localparam logic [PHASE_W-1:0] PH_NAME  = 5'd20;
  localparam logic [PHASE_W-1:0] PH_PAD   = 5'd21;
  localparam logic [PHASE_W-1:0] PH_DONE  = 5'd22;
  localparam logic [PHASE_W-1:0] KIND_OFS = 5'd2;  // entry word kind = phase - 2

  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_e;
  logic [1:0]         bif_r, bif_nxt, bif_e;
  logic [23:0]        acc_r, acc_nxt, acc_e;
  logic [WORD_W-1:0]  left_r, left_nxt, left_e;
  logic [WORD_W-1:0]  idx_r, idx_nxt, idx_e;
  logic [NLEN_W-1:0]  name_r, name_nxt, name_e;
  logic [3:0]         pad_r, pad_nxt, pad_e;

  logic [WORD_W-1:0]  word;
  logic [MTYPE_W-1:0] mtype;
  logic [NLEN_W-1:0]  len;
  logic [2:0]         pad_mod;
  logic               full;
  logic               err;
  logic [ECODE_W-1:0] err_code;

  always_comb begin
    // a frame start restarts the parse before the byte is used
    phase_e = phase_r;
    bif_e   = bif_r;
    acc_e   = acc_r;
    left_e  = left_r;
    idx_e   = idx_r;
    name_e  = name_r;
    pad_e   = pad_r;
    if (item.frame_start) begin
      phase_e = PH_SIG;
      bif_e   = '0;
      acc_e   = '0;
      left_e  = '0;
      idx_e   = '0;
      name_e  = '0;
      pad_e   = '0;
    end

    phase_nxt = phase_e;
    bif_nxt   = bif_e;
    acc_nxt   = acc_e;
    left_nxt  = left_e;
    idx_nxt   = idx_e;
    name_nxt  = name_e;
    pad_nxt   = pad_e;
    res       = '0;
    res_valid = 1'b0;
    err       = 1'b0;
    err_code  = E_NONE;

    word    = {acc_e, item.data_byte};
    mtype   = word[15:12];
    len     = word[NLEN_W-1:0];
    pad_mod = FIXED_MOD8 + len[2:0];
    full    = (phase_e == PH_FLAGS) ? (bif_e == 2'd1) : (bif_e == 2'd3);

    case (phase_e)
      PH_IDLE, PH_DONE: begin
      end
      PH_NAME: begin
        res_valid          = 1'b1;
        res.kind           = K_NAME;
        res.value          = {{(WORD_W-BYTE_W){1'b0}}, item.data_byte};
        res.entry_number   = idx_e;
        name_nxt           = name_e - 12'd1;
        if (name_e == 12'd1) begin
          phase_nxt = PH_PAD;
        end
      end
      PH_PAD: begin
        pad_nxt = pad_e - 4'd1;
        if (pad_e == 4'd1) begin
          res_valid        = 1'b1;
          res.kind         = K_END;
          res.entry_number = idx_e;
          idx_nxt          = idx_e + 32'd1;
          left_nxt         = left_e - 32'd1;
          if (left_e == 32'd1) begin
            res.last  = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_FIRST;
          end
        end
      end
      default: begin
        if (phase_e > PH_FLAGS) begin
          phase_nxt = PH_DONE;
        end else if (!full) begin
          bif_nxt = bif_e + 2'd1;
          acc_nxt = word[23:0];
        end else begin
          bif_nxt = '0;
          acc_nxt = '0;
          case (phase_e)
            PH_SIG: begin
              if (word != SIG_WORD) begin
                err      = 1'b1;
                err_code = E_SIGNATURE;
              end else begin
                phase_nxt = PH_VER;
              end
            end
            PH_VER: begin
              res_valid = 1'b1;
              res.kind  = K_VERSION;
              res.value = word;
              phase_nxt = PH_CNT;
            end
            PH_CNT: begin
              res_valid = 1'b1;
              res.kind  = K_COUNT;
              res.value = word;
              left_nxt  = word;
              if (word == '0) begin
                res.last  = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_FIRST;
              end
            end
            PH_MODE: begin
              if (word[31:16] != 16'd0) begin
                err      = 1'b1;
                err_code = E_UNUSED;
              end else if (mtype != MT_REGULAR && mtype != MT_SYMLINK &&
                           mtype != MT_GITLINK) begin
                err      = 1'b1;
                err_code = E_MODE_TYPE;
              end else begin
                res_valid        = 1'b1;
                res.kind         = phase_e - KIND_OFS;
                res.value        = word;
                res.entry_number = idx_e;
                res.file_type    = mtype;
                res.perm_bits    = word[PERMS_W-1:0];
                phase_nxt        = phase_e + 5'd1;
              end
            end
            PH_FLAGS: begin
              if ((word[15:0] & FL_EXTENDED) != 16'd0) begin
                err      = 1'b1;
                err_code = E_EXTENDED;
              end else if (len == NAME_MAX) begin
                err      = 1'b1;
                err_code = E_LONG_NAME;
              end else begin
                res_valid        = 1'b1;
                res.kind         = K_FLAGS;
                res.value        = {16'd0, word[15:0]};
                res.entry_number = idx_e;
                res.assume_valid = (word[15:0] & FL_ASSUME) != 16'd0;
                res.stage        = word[13:12];
                res.name_len     = len;
                name_nxt         = len;
                pad_nxt          = 4'd8 - {1'b0, pad_mod};
                phase_nxt        = (len != '0) ? PH_NAME : PH_PAD;
              end
            end
            default: begin
              res_valid        = 1'b1;
              res.kind         = phase_e - KIND_OFS;
              res.value        = word;
              res.entry_number = idx_e;
              phase_nxt        = phase_e + 5'd1;
            end
          endcase
        end
      end
    endcase

    // errors are sticky until the next frame start
    if (err) begin
      res_valid        = 1'b1;
      res              = '0;
      res.kind         = K_ERROR;
      res.entry_number = idx_e;
      res.error_code   = err_code;
      res.last         = 1'b1;
      phase_nxt        = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bif_r   <= '0;
      acc_r   <= '0;
      left_r  <= '0;
      idx_r   <= '0;
      name_r  <= '0;
      pad_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      name_r  <= name_nxt;
      pad_r   <= pad_nxt;
    end
  end

  `ASSERT_HOLDS(a_name_nonzero, phase_r == PH_NAME, name_r != '0, "name phase with no bytes left")
  `ASSERT_HOLDS(a_pad_nonzero, phase_r == PH_PAD, pad_r != '0, "pad phase with no bytes left")
  `ASSERT_HOLDS(a_flags_short, phase_r == PH_FLAGS, bif_r <= 2'd1, "flags field overran two bytes")
  `ASSERT_NEXT(a_done_stays, step && !item.frame_start && phase_r == PH_DONE, phase_r == PH_DONE, "left done without frame start")
endmodule

[rtl/iesp_out_reg.sv]
// result register driving the output channel
`include "assert_macros.svh"
module iesp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           res_valid,
  input  iesp_pkg::res_t res,
  output logic           advance,
  iesp_out_if.source     out_chan
);
  import iesp_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign advance = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.kind         = res_r.kind;
  assign out_chan.value        = res_r.value;
  assign out_chan.entry_number = res_r.entry_number;
  assign out_chan.file_type    = res_r.file_type;
  assign out_chan.perm_bits    = res_r.perm_bits;
  assign out_chan.assume_valid = res_r.assume_valid;
  assign out_chan.stage        = res_r.stage;
  assign out_chan.name_len     = res_r.name_len;
  assign out_chan.error_code   = res_r.error_code;
  assign out_chan.last         = res_r.last;

  `ASSERT_HOLDS(a_err_last, valid_r && res_r.kind == K_ERROR, res_r.last && res_r.error_code != E_NONE, "error result without last or code")
endmodule
